/* rtl/swls_pkg.sv */
package swls_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SEQ_W      = 5;
    localparam logic [SEQ_W-1:0] SEQ_MAX = 5'd25;
    localparam int RES_MAX    = 3;

    // input commands
    localparam logic [1:0] CMD_QUEUE = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [2:0] K_QUEUED  = 3'd0;
    localparam logic [2:0] K_TX      = 3'd1;
    localparam logic [2:0] K_ACK     = 3'd2;
    localparam logic [2:0] K_ERR     = 3'd3;
    localparam logic [2:0] K_TOUT    = 3'd4;
    localparam logic [2:0] K_DELIVER = 3'd5;
    localparam logic [2:0] K_PEER    = 3'd6;
    localparam logic [2:0] K_REFUSED = 3'd7;

    // error codes
    localparam logic [7:0] E_BAD_START = 8'd1;
    localparam logic [7:0] E_BAD_SIZE  = 8'd2;
    localparam logic [7:0] E_UNK_CTRL  = 8'd3;
    localparam logic [7:0] E_UNK_TOP   = 8'd4;
    localparam logic [7:0] E_BAD_SEQ   = 8'd5;
    localparam logic [7:0] E_RESEND    = 8'd6;

    // line characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_D     = 8'h44;

    // config register indexes
    localparam logic [1:0] REG_RESEND  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0] seq;
        logic [7:0]       code;
    } t_res;

    typedef struct packed {
        logic latch;
        logic eval;
        logic walk;
        logic fin;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic go_walk;
        logic walk_done;
        logic no_res;
        logic at_last;
    } t_stat;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        logic [SEQ_W-1:0] t;
        t = s + 1'b1;
        return (s >= SEQ_MAX) ? '0 : t;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

/* rtl/swls_ctrl.sv */
module swls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  swls_pkg::t_stat i_stat,
    output swls_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.go_walk ? S_WALK : S_DEC;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_DEC: begin
                n_state = i_stat.no_res ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.at_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/swls_dp.sv */
module swls_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_addr,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic [1:0]                       i_cmd,
    input  logic [7:0]                       i_line_len,
    input  logic [7:0]                       i_first_char,
    input  logic [7:0]                       i_second_char,
    input  logic [7:0]                       i_third_char,
    input  logic [31:0]                      i_now_ms,
    input  swls_pkg::t_cmd                   i_ctl,
    output swls_pkg::t_stat                  o_stat,
    output logic [2:0]                       o_out_kind,
    output logic [swls_pkg::SLOT_W-1:0]      o_out_slot,
    output logic [swls_pkg::SEQ_W-1:0]       o_out_seq,
    output logic [7:0]                       o_out_code,
    output logic                             o_last
);

    localparam int SW = swls_pkg::SLOT_W;
    localparam int QW = swls_pkg::SEQ_W;
    localparam int NS = swls_pkg::SLOT_COUNT;

    logic [7:0]  r_resend;
    logic [15:0] r_timeout;

    logic [1:0]  r_cmd;
    logic [7:0]  r_len, r_c0, r_c1, r_c2;
    logic [31:0] r_now;

    logic [QW-1:0] r_seq    [NS];
    logic [NS-1:0] r_acked;
    logic [31:0]   r_stime  [NS];
    logic [7:0]    r_retry  [NS];
    logic [SW-1:0] r_newest, r_oldest;
    logic [QW-1:0] r_tx_seq, r_rx_exp;
    logic          r_rtx_en;

    swls_pkg::t_res r_buf [swls_pkg::RES_MAX];
    logic [1:0]     r_cnt, r_rd;

    // evaluation results
    swls_pkg::t_res e_buf [swls_pkg::RES_MAX];
    logic [1:0]     e_cnt;
    logic           e_tx_en;
    logic [SW-1:0]  e_tx_slot;
    logic           e_adv;
    logic           e_dec_retry;
    logic           e_rx_upd;
    logic           e_en_set, e_en_val;

    logic [SW-1:0]  next_slot, o2;
    logic [7:0]     s_line, s_ack;
    logic [31:0]    elapsed;
    logic           ack_match, o2_acked;
    logic [QW-1:0]  rx_next, tx_next;

    assign next_slot = swls_pkg::slot_inc(r_newest);
    assign s_line    = r_c1 - swls_pkg::CH_A;
    assign s_ack     = r_c2 - swls_pkg::CH_A;
    assign elapsed   = r_now - r_stime[r_oldest];
    assign rx_next   = swls_pkg::seq_inc(r_rx_exp);
    assign tx_next   = swls_pkg::seq_inc(r_tx_seq);
    assign o2        = (r_oldest != r_newest) ? swls_pkg::slot_inc(r_oldest) : r_oldest;
    assign o2_acked  = (o2 != r_oldest) ? r_acked[o2] : 1'b1;
    assign ack_match = !r_acked[r_oldest]
                     && ({3'd0, swls_pkg::seq_inc(r_seq[r_oldest])} == s_ack);

    always_comb begin
        e_buf       = '{default: '0};
        e_cnt       = '0;
        e_tx_en     = 1'b0;
        e_tx_slot   = r_oldest;
        e_adv       = 1'b0;
        e_dec_retry = 1'b0;
        e_rx_upd    = 1'b0;
        e_en_set    = 1'b0;
        e_en_val    = 1'b0;
        case (r_cmd)
            swls_pkg::CMD_QUEUE: begin
                if (!r_acked[next_slot]) begin
                    e_buf[0].kind = swls_pkg::K_REFUSED;
                    e_cnt = 2'd1;
                end
            end
            swls_pkg::CMD_LINE: begin
                if (r_c0 == swls_pkg::CH_PLUS) begin
                    if (r_len < 8'd3) begin
                        e_buf[0].kind = swls_pkg::K_ERR;
                        e_buf[0].code = swls_pkg::E_BAD_SIZE;
                        e_cnt = 2'd1;
                    end else begin
                        if (r_c2 != swls_pkg::CH_SPACE) begin
                            e_buf[0].kind = swls_pkg::K_ERR;
                            e_buf[0].code = swls_pkg::E_BAD_SEQ;
                            e_cnt = 2'd1;
                        end
                        if (s_line == {3'd0, r_rx_exp}) begin
                            e_rx_upd = 1'b1;
                            e_buf[e_cnt].kind = swls_pkg::K_ACK;
                            e_buf[e_cnt].seq  = rx_next;
                            e_buf[e_cnt + 2'd1].kind = swls_pkg::K_DELIVER;
                            e_buf[e_cnt + 2'd1].seq  = s_line[QW-1:0];
                            e_cnt = e_cnt + 2'd2;
                        end else begin
                            e_buf[e_cnt].kind = swls_pkg::K_ACK;
                            e_buf[e_cnt].seq  = r_rx_exp;
                            e_cnt = e_cnt + 2'd1;
                        end
                    end
                end else if (r_c0 == swls_pkg::CH_HASH) begin
                    if (r_len != 8'd3) begin
                        e_buf[0].kind = swls_pkg::K_ERR;
                        e_buf[0].code = swls_pkg::E_BAD_SIZE;
                        e_cnt = 2'd1;
                    end else if (r_c1 == swls_pkg::CH_EQ) begin
                        if (ack_match) begin
                            e_adv = 1'b1;
                            if (!o2_acked) begin
                                e_tx_en   = 1'b1;
                                e_tx_slot = o2;
                                e_buf[0].kind = swls_pkg::K_TX;
                                e_buf[0].slot = o2;
                                e_buf[0].seq  = r_seq[o2];
                                e_cnt = 2'd1;
                            end
                        end
                    end else if (r_c1 == swls_pkg::CH_BANG) begin
                        e_buf[0].kind = swls_pkg::K_PEER;
                        e_buf[0].code = r_c2;
                        e_cnt = 2'd1;
                    end else if (r_c1 == swls_pkg::CH_T) begin
                        e_cnt = 2'd1;
                        if (r_c2 == swls_pkg::CH_PLUS || r_c2 == swls_pkg::CH_MINUS) begin
                            e_en_set = 1'b1;
                            e_en_val = (r_c2 == swls_pkg::CH_PLUS);
                            e_buf[0].kind = swls_pkg::K_TOUT;
                            e_buf[0].code = r_c2;
                        end else begin
                            e_buf[0].kind = swls_pkg::K_ERR;
                            e_buf[0].code = swls_pkg::E_UNK_TOP;
                        end
                    end else if (r_c1 != swls_pkg::CH_D) begin
                        // debug readout ('D') gives nothing
                        e_buf[0].kind = swls_pkg::K_ERR;
                        e_buf[0].code = swls_pkg::E_UNK_CTRL;
                        e_cnt = 2'd1;
                    end
                end else if (r_c0 != swls_pkg::CH_GT) begin
                    e_buf[0].kind = swls_pkg::K_ERR;
                    e_buf[0].code = swls_pkg::E_BAD_START;
                    e_cnt = 2'd1;
                end
            end
            swls_pkg::CMD_TICK: begin
                if (r_rtx_en && !r_acked[r_oldest] && elapsed > {16'd0, r_timeout}) begin
                    e_cnt = 2'd1;
                    if (r_retry[r_oldest] != 8'd0) begin
                        e_tx_en     = 1'b1;
                        e_dec_retry = 1'b1;
                        e_buf[0].kind = swls_pkg::K_TX;
                        e_buf[0].slot = r_oldest;
                        e_buf[0].seq  = r_seq[r_oldest];
                    end else begin
                        e_adv = 1'b1;
                        e_buf[0].kind = swls_pkg::K_ERR;
                        e_buf[0].code = swls_pkg::E_RESEND;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_stat.go_walk   = (r_cmd == swls_pkg::CMD_QUEUE) && r_acked[next_slot];
    assign o_stat.walk_done = !r_acked[r_oldest] || (r_oldest == r_newest);
    assign o_stat.no_res    = (r_cnt == 2'd0);
    assign o_stat.at_last   = (r_rd == r_cnt - 2'd1);

    assign o_out_kind = r_buf[r_rd].kind;
    assign o_out_slot = r_buf[r_rd].slot;
    assign o_out_seq  = r_buf[r_rd].seq;
    assign o_out_code = r_buf[r_rd].code;
    assign o_last     = o_stat.at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resend  <= 8'd3;
            r_timeout <= 16'd100;
            r_acked   <= '1;
            r_newest  <= '0;
            r_oldest  <= '0;
            r_tx_seq  <= swls_pkg::SEQ_MAX;
            r_rx_exp  <= '0;
            r_rtx_en  <= 1'b0;
            r_cnt     <= '0;
            r_rd      <= '0;
            for (int i = 0; i < NS; i++) begin
                r_seq[i]   <= '0;
                r_stime[i] <= '0;
                r_retry[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == swls_pkg::REG_RESEND)  r_resend  <= i_cfg_wdata[7:0];
                if (i_cfg_addr == swls_pkg::REG_TIMEOUT) r_timeout <= i_cfg_wdata;
            end
            if (i_ctl.eval) begin
                r_buf <= e_buf;
                r_cnt <= e_cnt;
                r_rd  <= '0;
                if (o_stat.go_walk) r_newest <= next_slot;
                if (e_adv) begin
                    r_acked[r_oldest] <= 1'b1;
                    r_oldest <= o2;
                end
                if (e_tx_en) begin
                    r_acked[e_tx_slot] <= 1'b0;
                    r_stime[e_tx_slot] <= r_now;
                end
                if (e_dec_retry) r_retry[r_oldest] <= r_retry[r_oldest] - 8'd1;
                if (e_rx_upd) r_rx_exp <= rx_next;
                if (e_en_set) r_rtx_en <= e_en_val;
            end
            if (i_ctl.walk && !o_stat.walk_done) r_oldest <= swls_pkg::slot_inc(r_oldest);
            if (i_ctl.fin) begin
                r_tx_seq <= tx_next;
                r_seq[r_newest]   <= tx_next;
                r_acked[r_newest] <= 1'b0;
                r_retry[r_newest] <= r_resend;
                r_stime[r_newest] <= (r_oldest == r_newest) ? r_now : 32'd0;
                r_buf[0] <= '{kind: swls_pkg::K_QUEUED, slot: r_newest, seq: tx_next,
                              code: 8'd0};
                r_buf[1] <= '{kind: swls_pkg::K_TX, slot: r_newest, seq: tx_next,
                              code: 8'd0};
                r_cnt <= (r_oldest == r_newest) ? 2'd2 : 2'd1;
                r_rd  <= '0;
            end
            if (i_ctl.pop) r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= i_cmd;
            r_len <= i_line_len;
            r_c0  <= i_first_char;
            r_c1  <= i_second_char;
            r_c2  <= i_third_char;
            r_now <= i_now_ms;
        end
    end

endmodule

/* rtl/stop_and_wait_link_sequencer.sv */
// Sequence: an input transfer is latched, evaluated and then passed through a decision
//   state before its results; an accepted queue request instead walks the slot ring
//   and a finish state. Results then follow one a cycle while the receiver is ready.
// Flow: one item at a time; next input taken the cycle after the last result
//   transfer, or after the decision state for an item with no result.
// Reset: synchronous active-low; all slots acknowledged, tx sequence at maximum,
//   resend limit 3, timeout 100 ms, retransmission off.
module stop_and_wait_link_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input item
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_line_len,
    input  logic [7:0]  i_first_char,
    input  logic [7:0]  i_second_char,
    input  logic [7:0]  i_third_char,
    input  logic [31:0] i_now_ms,
    // result item
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_out_kind,
    output logic [1:0]  o_out_slot,
    output logic [4:0]  o_out_seq,
    output logic [7:0]  o_out_code,
    output logic        o_last
);

    swls_pkg::t_cmd  ctl;
    swls_pkg::t_stat stat;

    // controller: sequences latch, evaluate, slot walk, finish and result drain
    swls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (ctl)
    );

    // datapath: slot ring, sequence counters and the small result buffer
    swls_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_line_len    (i_line_len),
        .i_first_char  (i_first_char),
        .i_second_char (i_second_char),
        .i_third_char  (i_third_char),
        .i_now_ms      (i_now_ms),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_out_kind    (o_out_kind),
        .o_out_slot    (o_out_slot),
        .o_out_seq     (o_out_seq),
        .o_out_code    (o_out_code),
        .o_last        (o_last)
    );

endmodule

/* rtl/swls_checker.sv */
module swls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_out_kind,
    input logic       o_last
);

    // never take an item while results are still pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready while result pending");

    // one item in flight
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("second item taken");

    // after the final result transfer the block is free again
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (o_ready && !o_valid))
        else $error("not idle after last result");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_kind) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind stop_and_wait_link_sequencer swls_checker u_swls_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_kind (o_out_kind),
    .o_last     (o_last)
);

/* tb/sv/tb_top.sv */
module tb_top;

    // ---------------------------------------------------------------
    // Clock, reset and block ports
    // ---------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [7:0]  i_line_len = '0;
    logic [7:0]  i_first_char = '0;
    logic [7:0]  i_second_char = '0;
    logic [7:0]  i_third_char = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_out_kind;
    logic [1:0]  o_out_slot;
    logic [4:0]  o_out_seq;
    logic [7:0]  o_out_code;
    logic        o_last;

    always #5 i_clk = ~i_clk;

    stop_and_wait_link_sequencer dut (.*);

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] slot;
        logic [4:0] seq;
        logic [7:0] code;
        logic       last;
    } t_link_res;

    // ---------------------------------------------------------------
    // Scoreboard: own copy of the sequencer state, predicts the
    // results of every accepted input transfer and checks each
    // accepted result against the oldest one outstanding.
    // ---------------------------------------------------------------
    class link_scoreboard;
        t_link_res   pending[$];
        int          errors;
        logic [7:0]  resend_lim;
        logic [15:0] tmo;
        logic [4:0]  seq_of[swls_pkg::SLOT_COUNT];
        bit          acked[swls_pkg::SLOT_COUNT];
        logic [31:0] sent_at[swls_pkg::SLOT_COUNT];
        logic [7:0]  tries[swls_pkg::SLOT_COUNT];
        logic [1:0]  newest, oldest;
        logic [4:0]  tx_sq, rx_sq;
        bit          retx_on;
        t_link_res   batch[$];

        function new();
            errors = 0;
            resend_lim = 8'd3;
            tmo = 16'd100;
            for (int i = 0; i < swls_pkg::SLOT_COUNT; i++) begin
                seq_of[i] = '0;
                acked[i] = 1'b1;
                sent_at[i] = '0;
                tries[i] = '0;
            end
            newest = '0;
            oldest = '0;
            tx_sq = swls_pkg::SEQ_MAX;
            rx_sq = '0;
            retx_on = 1'b0;
        endfunction

        function logic [4:0] wrap_inc(logic [4:0] s);
            return (s >= swls_pkg::SEQ_MAX) ? 5'd0 : s + 5'd1;
        endfunction

        function void add(logic [2:0] k, logic [1:0] sl, logic [4:0] sq, logic [7:0] c);
            t_link_res r;
            r = '{kind: k, slot: sl, seq: sq, code: c, last: 1'b0};
            batch.push_back(r);
        endfunction

        function void retire_oldest();
            acked[oldest] = 1'b1;
            if (oldest != newest) oldest = oldest + 2'd1;
        endfunction

        function void send_slot(logic [1:0] sl, logic [31:0] now);
            acked[sl] = 1'b0;
            sent_at[sl] = now;
            add(swls_pkg::K_TX, sl, seq_of[sl], 8'd0);
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == swls_pkg::REG_RESEND) resend_lim = val[7:0];
            else if (idx == swls_pkg::REG_TIMEOUT) tmo = val;
        endfunction

        // Note an accepted input transfer; returns number of results.
        function int note_input(logic [1:0] cmd, logic [7:0] len, logic [7:0] c0,
                                logic [7:0] c1, logic [7:0] c2, logic [31:0] now);
            logic [1:0] nxt;
            logic [7:0] s;
            batch.delete();
            if (cmd == swls_pkg::CMD_QUEUE) begin
                nxt = newest + 2'd1;
                if (!acked[nxt]) begin
                    add(swls_pkg::K_REFUSED, 2'd0, 5'd0, 8'd0);
                end else begin
                    newest = nxt;
                    for (int i = 0; i < swls_pkg::SLOT_COUNT; i++) begin
                        if (!acked[oldest] || oldest == newest) break;
                        retire_oldest();
                    end
                    tx_sq = wrap_inc(tx_sq);
                    seq_of[nxt] = tx_sq;
                    acked[nxt] = 1'b0;
                    sent_at[nxt] = '0;
                    tries[nxt] = resend_lim;
                    add(swls_pkg::K_QUEUED, nxt, tx_sq, 8'd0);
                    if (oldest == nxt) send_slot(nxt, now);
                end
            end else if (cmd == swls_pkg::CMD_LINE) begin
                if (c0 == swls_pkg::CH_PLUS) begin
                    if (len < 8'd3) begin
                        add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_BAD_SIZE);
                    end else begin
                        if (c2 != swls_pkg::CH_SPACE)
                            add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_BAD_SEQ);
                        s = c1 - swls_pkg::CH_A;
                        if (s == {3'd0, rx_sq}) begin
                            rx_sq = wrap_inc(rx_sq);
                            add(swls_pkg::K_ACK, 2'd0, rx_sq, 8'd0);
                            add(swls_pkg::K_DELIVER, 2'd0, s[4:0], 8'd0);
                        end else begin
                            add(swls_pkg::K_ACK, 2'd0, rx_sq, 8'd0);
                        end
                    end
                end else if (c0 == swls_pkg::CH_HASH) begin
                    if (len != 8'd3) begin
                        add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_BAD_SIZE);
                    end else if (c1 == swls_pkg::CH_EQ) begin
                        s = c2 - swls_pkg::CH_A;
                        if (!acked[oldest] && {3'd0, wrap_inc(seq_of[oldest])} == s) begin
                            retire_oldest();
                            if (!acked[oldest]) send_slot(oldest, now);
                        end
                    end else if (c1 == swls_pkg::CH_BANG) begin
                        add(swls_pkg::K_PEER, 2'd0, 5'd0, c2);
                    end else if (c1 == swls_pkg::CH_T) begin
                        if (c2 == swls_pkg::CH_PLUS || c2 == swls_pkg::CH_MINUS) begin
                            retx_on = (c2 == swls_pkg::CH_PLUS);
                            add(swls_pkg::K_TOUT, 2'd0, 5'd0, c2);
                        end else begin
                            add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_UNK_TOP);
                        end
                    end else if (c1 != swls_pkg::CH_D) begin
                        // 'D' is the debug readout: silently ignored
                        add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_UNK_CTRL);
                    end
                end else if (c0 != swls_pkg::CH_GT) begin
                    add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_BAD_START);
                end
            end else if (cmd == swls_pkg::CMD_TICK) begin
                if (retx_on && !acked[oldest] && (now - sent_at[oldest]) > {16'd0, tmo}) begin
                    if (tries[oldest] > 0) begin
                        send_slot(oldest, now);
                        tries[oldest] = tries[oldest] - 8'd1;
                    end else begin
                        add(swls_pkg::K_ERR, 2'd0, 5'd0, swls_pkg::E_RESEND);
                        retire_oldest();
                    end
                end
            end
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) pending.push_back(batch[i]);
            return batch.size();
        endfunction

        function void check_result(t_link_res got);
            t_link_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, got.kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.slot != want.slot) begin
                $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
                errors++;
            end
            if (got.seq != want.seq) begin
                $display("%0t: seq exp %0d got %0d", $time, want.seq, got.seq);
                errors++;
            end
            if (got.code != want.code) begin
                $display("%0t: code exp %0d got %0d", $time, want.code, got.code);
                errors++;
            end
            if (got.last != want.last) begin
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    link_scoreboard sb = new();

    // ---------------------------------------------------------------
    // Monitors: sample both transfers at the rising edge
    // ---------------------------------------------------------------
    int idle_cycles = 0;
    int results_seen = 0;
    int n_dummy;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                n_dummy = sb.note_input(i_cmd, i_line_len, i_first_char, i_second_char,
                                        i_third_char, i_now_ms);
            if (o_valid && i_ready) begin
                sb.check_result('{kind: o_out_kind, slot: o_out_slot, seq: o_out_seq,
                                  code: o_out_code, last: o_last});
                results_seen++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Watchdog: long runs of cycles with no transfer at all
    always @(posedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern, plus one long hold-off on request
    // ---------------------------------------------------------------
    int  rx_mode = 0;        // 0 always ready, 1 random stalls
    bit  rx_hold_req = 1'b0;

    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            if (rx_mode == 0) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ---------------------------------------------------------------
    // Sender tasks
    // ---------------------------------------------------------------
    logic [31:0] clock_ms = 32'd0;
    int          burst_left = 0;

    task automatic send_item(logic [1:0] cmd, logic [7:0] len, logic [7:0] c0,
                             logic [7:0] c1, logic [7:0] c2, logic [31:0] now);
        int gap;
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_line_len    <= len;
        i_first_char  <= c0;
        i_second_char <= c1;
        i_third_char  <= c2;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        @(negedge i_clk);
        // gaps between bursts; valid stays high inside a burst
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);   // silent items may still be in flight
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // One random item, mostly well-formed protocol traffic
    task automatic random_item();
        int pick;
        logic [7:0] ack_c;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 150);
        ack_c = swls_pkg::CH_A + {3'd0, sb.wrap_inc(sb.seq_of[sb.oldest])};
        if (pick < 22)
            send_item(swls_pkg::CMD_QUEUE, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), clock_ms);
        else if (pick < 40)
            send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_EQ,
                      ($urandom_range(0, 4) != 0) ? ack_c : 8'($urandom), clock_ms);
        else if (pick < 55)
            send_item(swls_pkg::CMD_LINE, 8'($urandom_range(3, 40)), swls_pkg::CH_PLUS,
                      swls_pkg::CH_A + 8'($urandom_range(0, 27)),
                      ($urandom_range(0, 5) != 0) ? swls_pkg::CH_SPACE : 8'($urandom),
                      clock_ms);
        else if (pick < 75)
            send_item(swls_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom),
                      ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_ms);
        else if (pick < 82)
            send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_T,
                      ($urandom_range(0, 3) != 0) ? swls_pkg::CH_PLUS : swls_pkg::CH_MINUS,
                      clock_ms);
        else if (pick < 88)
            send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH,
                      ($urandom_range(0, 1) != 0) ? swls_pkg::CH_BANG : 8'($urandom),
                      8'($urandom), clock_ms);
        else
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 32'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int wait_end;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: framing errors and control lines
        send_item(swls_pkg::CMD_LINE, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd2, swls_pkg::CH_PLUS, swls_pkg::CH_A,
                  swls_pkg::CH_SPACE, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd255, swls_pkg::CH_PLUS, swls_pkg::CH_A,
                  swls_pkg::CH_SPACE, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_PLUS, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_PLUS, swls_pkg::CH_A + 8'd1,
                  8'h00, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd4, swls_pkg::CH_HASH, swls_pkg::CH_EQ,
                  swls_pkg::CH_A, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_BANG,
                  8'hFF, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_T, 8'h00, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_D,
                  swls_pkg::CH_A, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, 8'hFF, swls_pkg::CH_A, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_GT, swls_pkg::CH_A,
                  swls_pkg::CH_A, 32'd0);
        send_item(2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_item(swls_pkg::CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd500);
        // queue until refused, ack mismatch, then proper ack
        repeat (5) send_item(swls_pkg::CMD_QUEUE, 8'd0, 8'd0, 8'd0, 8'd0, 32'd10);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_EQ,
                  swls_pkg::CH_A + 8'd9, 32'd20);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_EQ,
                  swls_pkg::CH_A + 8'd1, 32'd20);
        // retransmit on timeout, then give up, with wrap of elapsed time
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_T,
                  swls_pkg::CH_PLUS, 32'd0);
        repeat (4) send_item(swls_pkg::CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_0000);
        send_item(swls_pkg::CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        send_item(swls_pkg::CMD_LINE, 8'd3, swls_pkg::CH_HASH, swls_pkg::CH_T,
                  swls_pkg::CH_MINUS, 32'd0);
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(swls_pkg::REG_RESEND, 16'd0);
                    cfg_write(swls_pkg::REG_TIMEOUT, 16'd0);
                end
                1: begin
                    cfg_write(swls_pkg::REG_RESEND, 16'd255);
                    cfg_write(swls_pkg::REG_TIMEOUT, 16'hFFFF);
                end
                2: begin
                    cfg_write(swls_pkg::REG_RESEND, 16'hFF02);
                    cfg_write(swls_pkg::REG_TIMEOUT, 16'd50);
                end
                default: begin
                    cfg_write(swls_pkg::REG_RESEND, 16'($urandom_range(0, 5)));
                    cfg_write(swls_pkg::REG_TIMEOUT, 16'($urandom_range(0, 300)));
                end
            endcase
            rx_mode = ph % 2;
            for (int k = 0; k < 65; k++) begin
                if (ph == 2 && k == 10) rx_hold_req = 1'b1;   // long receiver hold-off
                if (ph == 3 && k == 30) drain();              // sender waits for all results
                random_item();
            end
            drain();
        end

        wait_end = 0;
        while (sb.pending.size() != 0 && wait_end < 5000) begin
            @(negedge i_clk);
            wait_end++;
        end
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* stop_and_wait_link_sequencer.f */
rtl/swls_pkg.sv
rtl/swls_ctrl.sv
rtl/swls_dp.sv
rtl/stop_and_wait_link_sequencer.sv
rtl/swls_checker.sv
tb/sv/tb_top.sv
